>>> rtl/core/ambiguous_base_window_mask_defines.svh
// Assertion macros for the ambiguous base window mask checker.
// Depends on nothing; included by the checker file.
`ifndef AMBIGUOUS_BASE_WINDOW_MASK_DEFINES_SVH
`define AMBIGUOUS_BASE_WINDOW_MASK_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ABWM_ASSERT_IMPL(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ABWM_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

>>> rtl/core/abwm_pkg.sv
// Shared types, constants and the ambiguity test for the base window mask.
// Depends on nothing; imported by every module of the block.
package abwm_pkg;

    localparam int MAX_WINDOW_DEF = 15;

    localparam int BASE_W = 8;
    localparam int WIN_W  = 4;
    localparam int MIN_W  = 5;
    localparam int CFG_W  = 5;
    localparam int IDX_W  = 1;
    localparam int CNT_W  = WIN_W + 1;

    localparam logic [BASE_W-1:0] GAP_CHAR  = 8'h2D;
    localparam logic [BASE_W-1:0] MASK_CHAR = 8'h4E;
    localparam logic [MIN_W-1:0]  MIN_AMBIG_RESET = 5'd2;

    localparam logic [IDX_W-1:0] REG_WINDOW_SIZE   = 1'b0;
    localparam logic [IDX_W-1:0] REG_MIN_AMBIGUOUS = 1'b1;

    typedef struct packed {
        logic [BASE_W-1:0] masked_base;
        logic              last_res;
    } res_t;

    // One item's pending results: start age, how many remain, flags.
    typedef struct packed {
        logic [WIN_W-1:0] age;
        logic [CNT_W-1:0] cnt;
        logic             last;
        logic             bypass;
    } job_t;

    function automatic logic is_ambig(input logic [BASE_W-1:0] c);
        logic [BASE_W-1:0] up;
        logic              hit;
        up = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
        hit = 1'b0;
        if (c == GAP_CHAR)
        begin
            hit = 1'b1;
        end
        else
        begin
            unique case (up)
                8'h52, 8'h59, 8'h53, 8'h57, 8'h4B, 8'h4D,
                8'h42, 8'h44, 8'h48, 8'h56, 8'h4E: hit = 1'b1;
                default:                            hit = 1'b0;
            endcase
        end
        return hit;
    endfunction

endpackage

>>> rtl/core/abwm_cell.sv
// One history cell: holds a base and the ambiguous count of it and newer bases.
// Depends on abwm_pkg.
module abwm_cell
    import abwm_pkg::*;
#(
    parameter int FW = 5
)
(
    input  logic              clk,
    input  logic              shift,
    input  logic              seq_start,
    input  logic              amb_new,
    input  logic [BASE_W-1:0] prev_base,
    input  logic [FW-1:0]     prev_cnt,
    output logic [BASE_W-1:0] base_out,
    output logic [FW-1:0]     cnt_out
);

    logic [BASE_W-1:0] base_reg;
    logic [FW-1:0]     cnt_reg;
    logic [FW-1:0]     cnt_next;

    // Drop the older prefix when a new sequence opens.
    assign cnt_next = {{(FW-1){1'b0}}, amb_new} + (seq_start ? '0 : prev_cnt);

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            base_reg <= prev_base;
            cnt_reg  <= cnt_next;
        end
    end

    assign base_out = base_reg;
    assign cnt_out  = cnt_reg;

endmodule

>>> rtl/core/abwm_chain.sv
// Row of history cells plus the fill count and the two read ports.
// Depends on abwm_pkg and abwm_cell.
module abwm_chain
    import abwm_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    localparam int HIST = 2 * MAX_WINDOW + 1,
    localparam int AW = $clog2(HIST),
    localparam int FW = $clog2(HIST + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift,
    input  logic [BASE_W-1:0] base_in,
    input  logic              last_in,
    input  logic [AW-1:0]     rd_age,
    input  logic [AW-1:0]     rd_hi,
    output logic [BASE_W-1:0] rd_base,
    output logic [FW-1:0]     rd_cnt,
    output logic [FW-1:0]     fill_after
);

    logic [BASE_W-1:0] base_q [HIST];
    logic [FW-1:0]     cnt_q  [HIST];
    logic [FW-1:0]     fill_reg;
    logic              new_seq_reg;
    logic              amb_new;

    assign amb_new = is_ambig(base_in);

    generate
        for (genvar i = 0; i < HIST; i++)
        begin : g_cell
            logic [BASE_W-1:0] pb;
            logic [FW-1:0]     pc;
            if (i == 0)
            begin : g_head
                assign pb = base_in;
                assign pc = '0;
            end
            else
            begin : g_body
                assign pb = base_q[i-1];
                assign pc = cnt_q[i-1];
            end
            abwm_cell #(.FW(FW)) u_cell (
                .clk       (clk),
                .shift     (shift),
                .seq_start (new_seq_reg),
                .amb_new   (amb_new),
                .prev_base (pb),
                .prev_cnt  (pc),
                .base_out  (base_q[i]),
                .cnt_out   (cnt_q[i])
            );
        end
    endgenerate

    always_comb
    begin
        if (new_seq_reg)
            fill_after = FW'(1);
        else if (fill_reg == FW'(HIST))
            fill_after = fill_reg;
        else
            fill_after = fill_reg + FW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            new_seq_reg <= 1'b1;
        end
        else if (shift)
        begin
            fill_reg    <= fill_after;
            new_seq_reg <= last_in;
        end
    end

    assign rd_base = base_q[rd_age];
    assign rd_cnt  = cnt_q[rd_hi];

endmodule

>>> rtl/core/abwm_emit.sv
// Result sequencer: holds one item's pending results, masks one a cycle if room.
// Depends on abwm_pkg.
module abwm_emit
    import abwm_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    localparam int HIST = 2 * MAX_WINDOW + 1,
    localparam int AW = $clog2(HIST),
    localparam int FW = $clog2(HIST + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              last_in,
    input  logic [FW-1:0]     fill_after,
    input  logic [WIN_W-1:0]  w_eff,
    input  logic [MIN_W-1:0]  min_ambiguous,
    input  logic [BASE_W-1:0] rd_base,
    input  logic [FW-1:0]     rd_cnt,
    input  logic              out_space,
    output logic [AW-1:0]     rd_age,
    output logic [AW-1:0]     rd_hi,
    output logic              push,
    output res_t              push_data,
    output logic              idle_next
);

    job_t             job_reg;
    job_t             job_next;
    logic [CNT_W-1:0] hi_sum;
    logic             hit;

    always_comb
    begin
        job_next.last   = last_in;
        job_next.bypass = 1'b0;
        if (w_eff == '0)
        begin
            job_next.age    = '0;
            job_next.cnt    = CNT_W'(1);
            job_next.bypass = 1'b1;
        end
        else if (int'(fill_after) > int'(w_eff))
        begin
            job_next.age = w_eff;
            job_next.cnt = last_in ? CNT_W'(w_eff) + CNT_W'(1) : CNT_W'(1);
        end
        else
        begin
            // Short sequence: flush every held base on last, else nothing yet.
            job_next.age = WIN_W'(fill_after) - WIN_W'(1);
            job_next.cnt = last_in ? CNT_W'(fill_after) : '0;
        end
    end

    assign hi_sum = CNT_W'(job_reg.age) + CNT_W'(w_eff);
    assign rd_age = AW'(job_reg.age);
    assign rd_hi  = AW'(hi_sum);

    assign hit = !job_reg.bypass && (int'(rd_cnt) >= int'(min_ambiguous));

    always_comb
    begin
        push_data.masked_base = rd_base;
        if (hit)
            push_data.masked_base = (rd_base == GAP_CHAR) ? GAP_CHAR : MASK_CHAR;
        push_data.last_res = job_reg.last && (job_reg.cnt == CNT_W'(1));
    end

    assign push      = (job_reg.cnt != '0) && out_space;
    assign idle_next = (job_reg.cnt == '0) || ((job_reg.cnt == CNT_W'(1)) && push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_reg <= '0;
        end
        else if (load)
        begin
            job_reg <= job_next;
        end
        else if (push)
        begin
            job_reg.cnt <= job_reg.cnt - CNT_W'(1);
            job_reg.age <= job_reg.age - WIN_W'(1);
        end
    end

endmodule

>>> rtl/core/abwm_obuf.sv
// Two-entry output queue that parts the sequencer from the result channel.
// Depends on abwm_pkg.
module abwm_obuf
    import abwm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    output logic space,
    output logic out_valid,
    input  logic out_stall,
    output res_t out_data
);

    res_t       data0_reg;
    res_t       data1_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign space     = (count_reg != 2'd2);
    assign pop       = out_valid && !out_stall;
    assign out_data  = data0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (push && !pop)
        begin
            count_reg <= count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            // Advance the queue; a same-cycle push lands where it belongs.
            if (push && count_reg == 2'd1)
                data0_reg <= push_data;
            else
                data0_reg <= data1_reg;
            if (push && count_reg == 2'd2)
                data1_reg <= push_data;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
                data0_reg <= push_data;
            else
                data1_reg <= push_data;
        end
    end

endmodule

>>> rtl/core/ambiguous_base_window_mask.sv
// Top level of the sliding-window ambiguous base mask.
// Depends on abwm_pkg, abwm_chain, abwm_emit and abwm_obuf.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+----------------------------
//   item     | item_valid / item_stall   | base[7:0], last
//   result   | result_valid/result_stall | masked_base[7:0], last_res
//   config   | cfg_valid / cfg_ready     | cfg_index, cfg_data[4:0]
//
// A non-last item is taken every cycle while the output queue has space;
// its result passes the job register and the output queue, window_size
// items behind. A last item stalls the item channel while the sequencer
// walks the history one base a cycle, as long as the output queue has space.
// Reset clears the fill count, the pending results and the output queue.
// A stalled result channel fills the two-entry queue, then stalls items.
module ambiguous_base_window_mask
    import abwm_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [BASE_W-1:0] base,
    input  logic              last,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [BASE_W-1:0] masked_base,
    output logic              last_res,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int HIST = 2 * MAX_WINDOW + 1;
    localparam int AW = $clog2(HIST);
    localparam int FW = $clog2(HIST + 1);

    logic [WIN_W-1:0]  window_size_reg;
    logic [MIN_W-1:0]  min_ambiguous_reg;
    logic [WIN_W-1:0]  w_eff;
    logic              accept;
    logic              idle_next;
    logic [AW-1:0]     rd_age;
    logic [AW-1:0]     rd_hi;
    logic [BASE_W-1:0] rd_base;
    logic [FW-1:0]     rd_cnt;
    logic [FW-1:0]     fill_after;
    logic              push;
    logic              space;
    res_t              push_data;
    res_t              out_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg   <= '0;
            min_ambiguous_reg <= MIN_AMBIG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WINDOW_SIZE:   window_size_reg   <= cfg_data[WIN_W-1:0];
                REG_MIN_AMBIGUOUS: min_ambiguous_reg <= cfg_data[MIN_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        if (int'(window_size_reg) > MAX_WINDOW)
            w_eff = WIN_W'(MAX_WINDOW);
        else
            w_eff = window_size_reg;
    end

    assign item_stall = !idle_next;
    assign accept     = item_valid && !item_stall;

    abwm_chain #(.MAX_WINDOW(MAX_WINDOW)) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift      (accept),
        .base_in    (base),
        .last_in    (last),
        .rd_age     (rd_age),
        .rd_hi      (rd_hi),
        .rd_base    (rd_base),
        .rd_cnt     (rd_cnt),
        .fill_after (fill_after)
    );

    abwm_emit #(.MAX_WINDOW(MAX_WINDOW)) u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .last_in       (last),
        .fill_after    (fill_after),
        .w_eff         (w_eff),
        .min_ambiguous (min_ambiguous_reg),
        .rd_base       (rd_base),
        .rd_cnt        (rd_cnt),
        .out_space     (space),
        .rd_age        (rd_age),
        .rd_hi         (rd_hi),
        .push          (push),
        .push_data     (push_data),
        .idle_next     (idle_next)
    );

    abwm_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .space     (space),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_data  (out_data)
    );

    assign masked_base = out_data.masked_base;
    assign last_res    = out_data.last_res;

endmodule

>>> rtl/core/abwm_checker.sv
// Port-level checker for the ambiguous base window mask, bound to the top level.
// Depends on abwm_pkg and ambiguous_base_window_mask_defines.svh.
`include "ambiguous_base_window_mask_defines.svh"

module abwm_checker
    import abwm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_stall,
    input logic [BASE_W-1:0] masked_base,
    input logic              last_res,
    input logic              cfg_valid,
    input logic              cfg_ready
);

    // A stalled result transfer keeps its valid and its payload.
    `ABWM_ASSERT_NEXT(a_res_hold, clk, !rst_n, result_valid && result_stall, result_valid)
    `ABWM_ASSERT_NEXT(a_res_stable, clk, !rst_n, result_valid && result_stall, $stable(masked_base) && $stable(last_res))
    // Reset empties the output queue.
    `ABWM_ASSERT_NEXT(a_reset_empty, clk, 1'b0, !rst_n, !result_valid)
    // Configuration is never back-pressured.
    `ABWM_ASSERT_IMPL(a_cfg_ready, clk, !rst_n, cfg_valid, cfg_ready)

endmodule

bind ambiguous_base_window_mask abwm_checker u_abwm_checker (.*);
